// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TDEC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TDEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/tdec_pkg.sv =====
package tdec_pkg;

  localparam int CODE_W  = 5;
  localparam int WORD_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int CODES_PER_WORD = 3;
  localparam int MAX_RES = 4;
  localparam int SLOT_W  = 2;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DICT = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Escape state.
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_T0   = 2'd1;
  localparam logic [1:0] ESC_T1   = 2'd2;

  // Code points.
  localparam logic [CODE_W-1:0] CODE_A      = 5'h00;
  localparam logic [CODE_W-1:0] CODE_Z      = 5'h19;
  localparam logic [CODE_W-1:0] CODE_SPACE  = 5'h1a;
  localparam logic [CODE_W-1:0] CODE_PERIOD = 5'h1b;
  localparam logic [CODE_W-1:0] CODE_LF     = 5'h1c;
  localparam logic [CODE_W-1:0] CODE_ESC0   = 5'h1d;
  localparam logic [CODE_W-1:0] CODE_ESC1   = 5'h1e;
  localparam logic [CODE_W-1:0] CODE_END    = 5'h1f;

  // ASCII values.
  localparam logic [CHAR_W-1:0] ASCII_A      = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_PERIOD = 8'h2e;
  localparam logic [CHAR_W-1:0] ASCII_LF     = 8'h0a;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_code;
    logic              dict_table;
    logic [CODE_W-1:0] dict_index;
  } result_t;

  // All results of one word, packed from slot 0 up.
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [SLOT_W-1:0]     last_idx;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/tdec_in_if.sv =====
interface tdec_in_if;
  logic                            valid;
  logic                            ready;
  logic [tdec_pkg::WORD_W-1:0]     packed_word;
  logic                            message_start;
  logic                            leading_newline;

  modport source (output valid, output packed_word, output message_start,
                  output leading_newline, input ready);
  modport sink   (input valid, input packed_word, input message_start,
                  input leading_newline, output ready);
endinterface

// ===== rtl/core/tdec_out_if.sv =====
interface tdec_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [tdec_pkg::CHAR_W-1:0]     char_code;
  logic                            dict_table;
  logic [tdec_pkg::CODE_W-1:0]     dict_index;
  logic                            last_of_item;

  modport source (output valid, output kind, output char_code, output dict_table,
                  output dict_index, output last_of_item, input ready);
  modport sink   (input valid, input kind, input char_code, input dict_table,
                  input dict_index, input last_of_item, output ready);
endinterface

// ===== rtl/core/tdec_front.sv =====
module tdec_front (
  input  logic              clk,
  input  logic              rst_n,
  tdec_in_if.sink           in_ch,
  input  tdec_pkg::q_stat_t q_stat,
  output logic              push,
  output tdec_pkg::bundle_t push_data
);

  logic [1:0] esc_r, esc_nxt;
  logic       act_r, act_nxt;
  logic [2:0] n_res;
  logic       accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (n_res != 3'd0);

  always_comb begin
    logic [1:0]                  esc;
    logic                        act;
    logic [2:0]                  n;
    logic [tdec_pkg::CODE_W-1:0] code;
    tdec_pkg::result_t           r;
    logic                        emit;

    esc = in_ch.message_start ? tdec_pkg::ESC_NONE : esc_r;
    act = in_ch.message_start ? 1'b1 : act_r;
    n   = 3'd0;
    push_data = '0;

    if (in_ch.message_start && in_ch.leading_newline) begin
      r = '0;
      r.kind = tdec_pkg::KIND_CHAR;
      r.char_code = tdec_pkg::ASCII_LF;
      push_data.res[0] = r;
      n = 3'd1;
    end

    for (int pos = 0; pos < tdec_pkg::CODES_PER_WORD; pos++) begin
      code = in_ch.packed_word[(tdec_pkg::CODES_PER_WORD - 1 - pos) * tdec_pkg::CODE_W
                               +: tdec_pkg::CODE_W];
      r    = '0;
      emit = 1'b0;
      if (act) begin
        if (esc != tdec_pkg::ESC_NONE) begin
          r.kind       = tdec_pkg::KIND_DICT;
          r.dict_table = (esc == tdec_pkg::ESC_T1);
          r.dict_index = code;
          emit = 1'b1;
          esc  = tdec_pkg::ESC_NONE;
        end else begin
          unique case (code) inside
            [tdec_pkg::CODE_A:tdec_pkg::CODE_Z]: begin
              r.char_code = {3'b000, code} + tdec_pkg::ASCII_A;
              emit = 1'b1;
            end
            tdec_pkg::CODE_SPACE: begin
              r.char_code = tdec_pkg::ASCII_SPACE;
              emit = 1'b1;
            end
            tdec_pkg::CODE_PERIOD: begin
              r.char_code = tdec_pkg::ASCII_PERIOD;
              emit = 1'b1;
            end
            tdec_pkg::CODE_LF: begin
              r.char_code = tdec_pkg::ASCII_LF;
              emit = 1'b1;
            end
            tdec_pkg::CODE_ESC0, tdec_pkg::CODE_ESC1: begin
              esc = (code == tdec_pkg::CODE_ESC1) ? tdec_pkg::ESC_T1 : tdec_pkg::ESC_T0;
            end
            default: begin
              r.kind = tdec_pkg::KIND_END;
              emit = 1'b1;
              act  = 1'b0;
              esc  = tdec_pkg::ESC_NONE;
            end
          endcase
        end
      end
      if (emit) begin
        push_data.res[n[tdec_pkg::SLOT_W-1:0]] = r;
        n = n + 3'd1;
      end
    end

    n_res   = n;
    push_data.last_idx = tdec_pkg::SLOT_W'(n - 3'd1);
    esc_nxt = esc;
    act_nxt = act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= tdec_pkg::ESC_NONE;
      act_r <= 1'b0;
    end else if (accept) begin
      esc_r <= esc_nxt;
      act_r <= act_nxt;
    end
  end

endmodule

// ===== rtl/core/tdec_fifo.sv =====
`include "assert_macros.svh"

module tdec_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tdec_pkg::bundle_t push_data,
  input  logic              pop,
  output tdec_pkg::bundle_t head,
  output tdec_pkg::q_stat_t q_stat
);

  tdec_pkg::bundle_t mem [tdec_pkg::QDEPTH];

  logic [tdec_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tdec_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tdec_pkg::CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == tdec_pkg::CNT_W'(tdec_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tdec_pkg::PTR_W'(tdec_pkg::QDEPTH - 1)) ? '0
                                                                       : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tdec_pkg::PTR_W'(tdec_pkg::QDEPTH - 1)) ? '0
                                                                       : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `TDEC_ASSERT(a_no_push_full, clk, rst_n, push |-> !q_stat.full, "push into full queue")
  `TDEC_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !q_stat.empty, "pop from empty queue")
  `TDEC_ASSERT(a_count_bound, clk, rst_n, count_r <= tdec_pkg::CNT_W'(tdec_pkg::QDEPTH), "queue count out of range")

endmodule

// ===== rtl/core/tdec_back.sv =====
`include "assert_macros.svh"

module tdec_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tdec_pkg::bundle_t head,
  input  tdec_pkg::q_stat_t q_stat,
  output logic              pop,
  tdec_out_if.source        out_ch
);

  logic [tdec_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  tdec_pkg::result_t           cur;
  logic                        is_last;
  logic                        beat;

  assign cur     = head.res[slot_r];
  assign is_last = (slot_r == head.last_idx);
  assign beat    = out_ch.valid && out_ch.ready;
  assign pop     = beat && is_last;

  assign out_ch.valid        = !q_stat.empty;
  assign out_ch.kind         = cur.kind;
  assign out_ch.char_code    = cur.char_code;
  assign out_ch.dict_table   = cur.dict_table;
  assign out_ch.dict_index   = cur.dict_index;
  assign out_ch.last_of_item = is_last;

  always_comb begin
    slot_nxt = slot_r;
    if (beat) begin
      slot_nxt = is_last ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  `TDEC_ASSERT(a_slot_in_bundle, clk, rst_n, out_ch.valid |-> (slot_r <= head.last_idx), "slot past last result")
  `TDEC_ASSERT(a_idle_slot_zero, clk, rst_n, !out_ch.valid |-> (slot_r == '0), "slot not rewound while idle")

endmodule

// ===== rtl/core/packed_five_bit_text_decoder_unit.sv =====
// Packed five-bit text decoder. Each input beat carries a 16-bit word with
// three 5-bit codes (bits 14:10 first, then 9:5, then 4:0; bit 15 unused) and
// the message_start and leading_newline flags. Every word produces zero to
// four result beats: letters, space, period and line feed as ASCII characters
// (kind 0), dictionary references after an escape code (kind 1, table 0 after
// code 29, table 1 after code 30, even across a word boundary), and the end
// marker (kind 2) for code 31, after which words are dropped until the next
// message start. The final result of each word carries last_of_item. Words
// that produce nothing (dropped words, words of escapes only) yield no beat.
// Rate: the front decodes a whole word combinationally and takes a word every
// cycle while the two-entry result queue has room; the back sends one result
// per cycle while the output is ready. The first result of a word is
// registered in the queue before it is offered on the output.

module packed_five_bit_text_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  tdec_in_if.sink    in_ch,
  tdec_out_if.source out_ch
);

  // Queue signals between the decode front and the serializing back.
  logic              push;
  logic              pop;
  tdec_pkg::bundle_t push_data;
  tdec_pkg::bundle_t head;
  tdec_pkg::q_stat_t q_stat;

  // The front keeps the escape and message state and turns one word into a
  // packed bundle of results, compacted from slot zero upward.
  tdec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // The queue decouples the two sides so that a stalled output does not
  // block decoding until the queue is full.
  tdec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // The back walks the head bundle one result per beat and pops it after
  // its last result has been taken.
  tdec_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/tb_packed_five_bit_text_decoder_unit.sv =====
module tb_packed_five_bit_text_decoder_unit;
  import tdec_pkg::*;

  // One expected or observed result beat: the decoded payload plus the flag
  // that marks the final beat caused by one input word.
  typedef struct packed {
    result_t res;
    logic    last;
  } text_beat_t;

  // One input word. When n_typed is not negative, the typed beats are the
  // expectation and the predictor only tracks state for that word.
  typedef struct {
    logic [WORD_W-1:0] word;
    logic              start;
    logic              lead;
    int                n_typed;
    text_beat_t        typed [MAX_RES];
  } stim_row_t;

  logic clk;
  logic rst_n;

  tdec_in_if  in_bus ();
  tdec_out_if out_bus ();

  packed_five_bit_text_decoder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Decoder state as the predictor sees it.
  logic [1:0] esc_state;
  logic       msg_live;

  // Beats that the decoder owes us, oldest first.
  text_beat_t text_due [$];
  stim_row_t  dir_rows [$];

  // When calm is set, neither side starts a new run of idle cycles.
  bit calm;

  int err_count;
  int words_sent;
  int live_words;
  int messages;
  int beats_checked;
  int dict_beats;
  int end_beats;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run, including full stalls on
  // both sides for every word.
  initial begin
    #2000000;
    $display("Timed out with %0d result beats still outstanding.", text_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (err_count < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    err_count++;
  endtask

  function automatic text_beat_t mk_beat(input logic [1:0] k, input logic [CHAR_W-1:0] c,
                                         input logic t, input logic [CODE_W-1:0] i,
                                         input logic lst);
    text_beat_t b;
    b.res.kind       = k;
    b.res.char_code  = c;
    b.res.dict_table = t;
    b.res.dict_index = i;
    b.last           = lst;
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] pack3(input logic [CODE_W-1:0] c0,
                                              input logic [CODE_W-1:0] c1,
                                              input logic [CODE_W-1:0] c2);
    return {1'b0, c0, c1, c2};
  endfunction

  // Predictor: decodes one word against the tracked escape and message state
  // and returns the beats the block must send for it.
  function automatic void decode_word(input logic [WORD_W-1:0] w, input logic s,
                                      input logic l, ref text_beat_t beats[$]);
    logic [CODE_W-1:0] code;
    int                pos;
    beats.delete();
    if (s) begin
      esc_state = ESC_NONE;
      msg_live  = 1'b1;
      if (l) begin
        beats.push_back(mk_beat(KIND_CHAR, ASCII_LF, 1'b0, '0, 1'b0));
      end
    end
    for (pos = 0; pos < CODES_PER_WORD && msg_live; pos++) begin
      // High code first: bits 14:10, then 9:5, then 4:0.
      code = w[14 - CODE_W * pos -: CODE_W];
      if (esc_state != ESC_NONE) begin
        // Whatever follows an escape is a dictionary index, controls included.
        beats.push_back(mk_beat(KIND_DICT, '0, esc_state == ESC_T1, code, 1'b0));
        esc_state = ESC_NONE;
      end else if (code <= CODE_Z) begin
        beats.push_back(mk_beat(KIND_CHAR, ASCII_A + {3'b000, code}, 1'b0, '0, 1'b0));
      end else if (code == CODE_SPACE) begin
        beats.push_back(mk_beat(KIND_CHAR, ASCII_SPACE, 1'b0, '0, 1'b0));
      end else if (code == CODE_PERIOD) begin
        beats.push_back(mk_beat(KIND_CHAR, ASCII_PERIOD, 1'b0, '0, 1'b0));
      end else if (code == CODE_LF) begin
        beats.push_back(mk_beat(KIND_CHAR, ASCII_LF, 1'b0, '0, 1'b0));
      end else if (code == CODE_ESC0) begin
        esc_state = ESC_T0;
      end else if (code == CODE_ESC1) begin
        esc_state = ESC_T1;
      end else begin
        beats.push_back(mk_beat(KIND_END, '0, 1'b0, '0, 1'b0));
        msg_live  = 1'b0;
        esc_state = ESC_NONE;
      end
    end
    if (beats.size() > 0) begin
      beats[beats.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_row(input logic [WORD_W-1:0] w, input logic s, input logic l,
                                  input int n = -1, input text_beat_t b0 = '0,
                                  input text_beat_t b1 = '0, input text_beat_t b2 = '0,
                                  input text_beat_t b3 = '0);
    stim_row_t r;
    r.word     = w;
    r.start    = s;
    r.lead     = l;
    r.n_typed  = n;
    r.typed[0] = b0;
    r.typed[1] = b1;
    r.typed[2] = b2;
    r.typed[3] = b3;
    dir_rows.push_back(r);
  endfunction

  // Drives one word and waits for its handshake. Expectations are queued
  // before the word is offered, so they are in place however fast the block is.
  task automatic present_word(input stim_row_t r);
    text_beat_t beats[$];
    int         gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (r.start || msg_live) begin
      live_words++;
    end
    if (r.start) begin
      messages++;
    end
    decode_word(r.word, r.start, r.lead, beats);
    if (r.n_typed >= 0) begin
      beats.delete();
      for (int i = 0; i < r.n_typed; i++) beats.push_back(r.typed[i]);
    end
    foreach (beats[i]) text_due.push_back(beats[i]);
    in_bus.valid           <= 1'b1;
    in_bus.packed_word     <= r.word;
    in_bus.message_start   <= r.start;
    in_bus.leading_newline <= r.lead;
    words_sent++;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_plain(input logic [WORD_W-1:0] w, input logic s, input logic l);
    stim_row_t r;
    r.word    = w;
    r.start   = s;
    r.lead    = l;
    r.n_typed = -1;
    present_word(r);
  endtask

  // Code mix for text: mostly letters, some punctuation and escapes, rare
  // ends, and a share of fully random codes.
  function automatic logic [CODE_W-1:0] rand_code();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return CODE_W'($urandom_range(0, 25));
    if (k < 82) return CODE_SPACE + CODE_W'($urandom_range(0, 2));
    if (k < 94) return $urandom_range(0, 1) ? CODE_ESC1 : CODE_ESC0;
    if (k < 96) return CODE_END;
    return CODE_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {1'($urandom_range(0, 1)), rand_code(), rand_code(), rand_code()};
  endfunction

  function automatic logic [WORD_W-1:0] end_word();
    logic [CODE_W-1:0] c [3];
    foreach (c[i]) c[i] = rand_code();
    c[$urandom_range(0, 2)] = CODE_END;
    return {1'($urandom_range(0, 1)), c[0], c[1], c[2]};
  endfunction

  // Result side: random backpressure, in bursts.
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin : check_out
    text_beat_t want;
    text_beat_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = mk_beat(out_bus.kind, out_bus.char_code, out_bus.dict_table,
                    out_bus.dict_index, out_bus.last_of_item);
      if (text_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d char=%02h tbl=%0d idx=%0d last=%0d",
                                  got.res.kind, got.res.char_code, got.res.dict_table,
                                  got.res.dict_index, got.last));
      end else begin
        want = text_due.pop_front();
        beats_checked++;
        if (want.res.kind == KIND_DICT) dict_beats++;
        if (want.res.kind == KIND_END) end_beats++;
        if (got.res.kind !== want.res.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.res.kind, want.res.kind));
        if (got.res.char_code !== want.res.char_code)
          report_mismatch($sformatf("char_code %02h, want %02h",
                                    got.res.char_code, want.res.char_code));
        if (got.res.dict_table !== want.res.dict_table)
          report_mismatch($sformatf("dict_table %0d, want %0d",
                                    got.res.dict_table, want.res.dict_table));
        if (got.res.dict_index !== want.res.dict_index)
          report_mismatch($sformatf("dict_index %0d, want %0d",
                                    got.res.dict_index, want.res.dict_index));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_of_item %0d, want %0d", got.last, want.last));
      end
    end
  end

  initial begin : stimulus
    int body;
    int pick;
    err_count     = 0;
    words_sent    = 0;
    live_words    = 0;
    messages      = 0;
    beats_checked = 0;
    dict_beats    = 0;
    end_beats     = 0;
    esc_state     = ESC_NONE;
    msg_live      = 1'b0;
    calm          = 1'b0;

    rst_n                  <= 1'b0;
    in_bus.valid           <= 1'b0;
    in_bus.packed_word     <= '0;
    in_bus.message_start   <= 1'b0;
    in_bus.leading_newline <= 1'b0;
    out_bus.ready          <= 1'b0;

    // Directed words. Rows with typed beats are simple enough to read off
    // by hand; the rest lean on the predictor.
    // Words before any message start are dropped, leading line feed or not.
    add_row(pack3(CODE_A, CODE_A, CODE_A), 1'b0, 1'b0, 0);
    add_row(16'hffff, 1'b0, 1'b1, 0);
    // Message start with a leading line feed, all-zero codes.
    add_row(16'h0000, 1'b1, 1'b1, 4,
            mk_beat(KIND_CHAR, ASCII_LF, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_A, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_A, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_A, 1'b0, '0, 1'b1));
    // All ones: the first code ends the message at once.
    add_row(16'hffff, 1'b1, 1'b0, 1, mk_beat(KIND_END, '0, 1'b0, '0, 1'b1));
    // Dropped after the end, then bit 15 alone is ignored in a new message.
    add_row(16'h8000, 1'b0, 1'b0, 0);
    add_row(16'h8000, 1'b1, 1'b0, 3,
            mk_beat(KIND_CHAR, ASCII_A, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_A, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_A, 1'b0, '0, 1'b1));
    add_row(pack3(CODE_Z, CODE_SPACE, CODE_PERIOD), 1'b0, 1'b0, 3,
            mk_beat(KIND_CHAR, 8'h5a, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_SPACE, 1'b0, '0, 1'b0),
            mk_beat(KIND_CHAR, ASCII_PERIOD, 1'b0, '0, 1'b1));
    // Leading line feed without a start is ignored.
    add_row(pack3(CODE_LF, 5'd7, 5'd24), 1'b0, 1'b1);
    // Escapes: one resolved in the word, one left pending across the boundary.
    add_row(pack3(CODE_ESC0, 5'd5, CODE_ESC1), 1'b0, 1'b0);
    // The pending escape swallows an end code as an index.
    add_row(pack3(CODE_END, 5'd2, CODE_ESC0), 1'b0, 1'b0);
    add_row(pack3(CODE_ESC1, CODE_ESC0, CODE_ESC0), 1'b0, 1'b0);
    // A pending escape is cleared by the next message start.
    add_row(pack3(5'd3, 5'd4, CODE_ESC1), 1'b0, 1'b0);
    add_row(pack3(5'd0, 5'd1, 5'd2), 1'b1, 1'b1);
    // End in the middle of a word drops the rest, and the next word too.
    add_row(pack3(5'd0, CODE_END, 5'd1), 1'b0, 1'b0);
    add_row(pack3(5'd0, 5'd0, 5'd0), 1'b0, 1'b0, 0);
    add_row(pack3(CODE_ESC0, CODE_END, CODE_END), 1'b1, 1'b0);
    add_row(16'h1234, 1'b0, 1'b1, 0);
    // Restart while a message is active.
    add_row(pack3(CODE_ESC1, 5'd9, 5'd10), 1'b1, 1'b1);
    add_row(pack3(CODE_ESC1, CODE_ESC1, CODE_LF), 1'b1, 1'b0);
    add_row(16'h7fff, 1'b0, 1'b0, 1, mk_beat(KIND_END, '0, 1'b0, '0, 1'b1));
    add_row(16'h5555, 1'b1, 1'b0);
    add_row(16'h2aaa, 1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) present_word(dir_rows[i]);

    // Random messages: a start word, a body of text, and usually an end.
    // Some messages are cut short by the next start, and noise words land
    // between messages where they should be dropped.
    while (words_sent < 270) begin
      calm = (words_sent >= 110 && words_sent < 150) || words_sent >= 220;
      pick = $urandom_range(0, 9);
      if (pick < 9) begin
        send_plain(rand_word(), 1'b1, 1'($urandom_range(0, 1)));
        body = $urandom_range(0, 5);
        repeat (body) send_plain(rand_word(), 1'b0, 1'($urandom_range(0, 1)));
        if (pick < 8) begin
          send_plain(end_word(), 1'b0, 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_plain(rand_word(), 1'b0, 1'($urandom_range(0, 1)));
      end
    end

    // Drain the result side, then give a stray beat time to show up.
    in_bus.valid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words (%0d decoded, %0d message starts).",
             words_sent, live_words, messages);
    $display("Checked %0d result beats: %0d dictionary references, %0d message ends.",
             beats_checked, dict_beats, end_beats);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
